// File: rtl/u2c_pkg.sv
// ----------------------------------------------------------------------------
// u2c_pkg
// shared types and constants for the utf-8 to code point decoder
// ----------------------------------------------------------------------------
package u2c_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LeftW   = 3;
  localparam int unsigned CodeW   = 21;
  localparam int unsigned BitsW   = 7;
  localparam int unsigned PendW   = 2;
  localparam int unsigned ContW   = 6;

  // byte patterns
  localparam logic [ByteW-1:0] AsciiMax  = 8'h7f;
  localparam logic [ByteW-1:0] ContMask  = 8'hc0;
  localparam logic [ByteW-1:0] ContTag   = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'he0;
  localparam logic [ByteW-1:0] Lead2Tag  = 8'hc0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hf0;
  localparam logic [ByteW-1:0] Lead3Tag  = 8'he0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hf8;
  localparam logic [ByteW-1:0] Lead4Tag  = 8'hf0;
  localparam logic [ByteW-1:0] Lead2Bits = 8'h1f;
  localparam logic [ByteW-1:0] Lead3Bits = 8'h0f;
  localparam logic [ByteW-1:0] Lead4Bits = 8'h07;
  localparam logic [ByteW-1:0] ContBits  = 8'h3f;

  // sequence lengths and bytes-left thresholds
  localparam logic [LeftW-1:0] LeftLast = 3'd1;
  localparam logic [LeftW-1:0] Need2    = 3'd2;
  localparam logic [LeftW-1:0] Need3    = 3'd3;
  localparam logic [LeftW-1:0] Need4    = 3'd4;

  localparam logic [PendW-1:0] PendNone = 2'd0;
  localparam logic [PendW-1:0] Pend1    = 2'd1;
  localparam logic [PendW-1:0] Pend2    = 2'd2;
  localparam logic [PendW-1:0] Pend3    = 2'd3;

  typedef enum logic [2:0] {
    KindAscii,
    KindLead2,
    KindLead3,
    KindLead4,
    KindCont,
    KindOther
  } byte_kind_e;

  // one classified byte as it sits in the queue
  typedef struct packed {
    byte_kind_e       kind;
    logic [BitsW-1:0] bits;
    logic             last;
  } entry_t;

  // queue to back end handshake
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_head_t;

endpackage

// File: rtl/u2c_front.sv
// ----------------------------------------------------------------------------
// u2c_front
// classifies one byte into its kind and pre-masked payload bits
// ----------------------------------------------------------------------------
module u2c_front (
  input  logic [u2c_pkg::ByteW-1:0] byte_value_i,
  input  logic [u2c_pkg::LeftW-1:0] bytes_left_i,
  output u2c_pkg::entry_t           entry_o
);

  logic [u2c_pkg::ByteW-1:0] masked;

  always_comb begin
    masked        = '0;
    entry_o.kind  = u2c_pkg::KindOther;
    entry_o.last  = (bytes_left_i == u2c_pkg::LeftLast);
    if (byte_value_i <= u2c_pkg::AsciiMax) begin
      entry_o.kind = u2c_pkg::KindAscii;
      masked       = byte_value_i;
    end else if ((byte_value_i & u2c_pkg::ContMask) == u2c_pkg::ContTag) begin
      entry_o.kind = u2c_pkg::KindCont;
      masked       = byte_value_i & u2c_pkg::ContBits;
    end else if ((byte_value_i & u2c_pkg::Lead2Mask) == u2c_pkg::Lead2Tag &&
                 bytes_left_i >= u2c_pkg::Need2) begin
      entry_o.kind = u2c_pkg::KindLead2;
      masked       = byte_value_i & u2c_pkg::Lead2Bits;
    end else if ((byte_value_i & u2c_pkg::Lead3Mask) == u2c_pkg::Lead3Tag &&
                 bytes_left_i >= u2c_pkg::Need3) begin
      entry_o.kind = u2c_pkg::KindLead3;
      masked       = byte_value_i & u2c_pkg::Lead3Bits;
    end else if ((byte_value_i & u2c_pkg::Lead4Mask) == u2c_pkg::Lead4Tag &&
                 bytes_left_i >= u2c_pkg::Need4) begin
      entry_o.kind = u2c_pkg::KindLead4;
      masked       = byte_value_i & u2c_pkg::Lead4Bits;
    end
    // leads too close to the end and invalid bytes stay other
    entry_o.bits = masked[u2c_pkg::BitsW-1:0];
  end

endmodule

// File: rtl/u2c_queue.sv
// ----------------------------------------------------------------------------
// u2c_queue
// short fifo of classified bytes between front and back end
// ----------------------------------------------------------------------------
module u2c_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  u2c_pkg::entry_t      entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output u2c_pkg::queue_head_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  u2c_pkg::entry_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == FullCnt);
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && (count_q != '0);
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: rtl/u2c_back.sv
// ----------------------------------------------------------------------------
// u2c_back
// sequence state, code point assembly and output register
// ----------------------------------------------------------------------------
module u2c_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  u2c_pkg::queue_head_t       head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [u2c_pkg::CodeW-1:0]  code_point_o,
  output logic                       code_valid_o,
  output logic                       end_of_string_o
);

  localparam int unsigned KeepW = u2c_pkg::CodeW - u2c_pkg::ContW;

  logic [u2c_pkg::PendW-1:0] pend_q, pend_d, pend_dec;
  logic [u2c_pkg::CodeW-1:0] acc_q, acc_d, acc_shift;
  logic                      out_valid_q, out_valid_d;
  logic [u2c_pkg::CodeW-1:0] cp_q, cp_n;
  logic                      cv_q, cv_n;
  logic                      eos_q;
  logic                      emit;
  u2c_pkg::entry_t           e;

  assign e     = head_i.entry;
  assign pop_o = head_i.valid && (!out_valid_q || out_ready_i);

  assign acc_shift = {acc_q[KeepW-1:0], e.bits[u2c_pkg::ContW-1:0]};
  assign pend_dec  = pend_q - 1'b1;

  always_comb begin
    pend_d = pend_q;
    acc_d  = acc_q;
    cv_n   = 1'b0;
    cp_n   = '0;
    if (pend_q != u2c_pkg::PendNone) begin
      if (e.kind == u2c_pkg::KindCont) begin
        pend_d = pend_dec;
        if (pend_dec == u2c_pkg::PendNone) begin
          cv_n  = 1'b1;
          cp_n  = acc_shift;
          acc_d = '0;
        end else begin
          acc_d = acc_shift;
        end
      end else begin
        // broken sequence, byte swallowed
        pend_d = u2c_pkg::PendNone;
        acc_d  = '0;
      end
    end else begin
      case (e.kind)
        u2c_pkg::KindAscii: begin
          cv_n = 1'b1;
          cp_n = u2c_pkg::CodeW'(e.bits);
        end
        u2c_pkg::KindLead2: begin
          acc_d  = u2c_pkg::CodeW'(e.bits);
          pend_d = u2c_pkg::Pend1;
        end
        u2c_pkg::KindLead3: begin
          acc_d  = u2c_pkg::CodeW'(e.bits);
          pend_d = u2c_pkg::Pend2;
        end
        u2c_pkg::KindLead4: begin
          acc_d  = u2c_pkg::CodeW'(e.bits);
          pend_d = u2c_pkg::Pend3;
        end
        default: begin
        end
      endcase
    end
    // string end always returns to idle
    if (e.last) begin
      pend_d = u2c_pkg::PendNone;
      acc_d  = '0;
    end
  end

  assign emit = cv_n || e.last;

  always_comb begin
    if (pop_o) begin
      out_valid_d = emit;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= u2c_pkg::PendNone;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        pend_q <= pend_d;
        acc_q  <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      cp_q  <= cp_n;
      cv_q  <= cv_n;
      eos_q <= e.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign code_point_o    = cp_q;
  assign code_valid_o    = cv_q;
  assign end_of_string_o = eos_q;

endmodule

// File: rtl/utf8_to_code_point_decoder_top.sv
// path: an accepted item is written into the queue, then the back end pops it into the output register
// throughput: one item per cycle while the output is taken; the back end retires one queued byte
// per cycle when no result is waiting, bytes with no result included
// stalls: a result waiting to be taken holds the back end, and the input keeps taking items
// until the queue holds QueueDepth of them
// reset: rst_ni low clears the queue, the sequence state and the output valid at once
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_top
// lenient utf-8 decoder, one byte per item, at most one code point per item
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder_top #(
  // entries in the queue between classifier and decoder, at least 1
  parameter int unsigned QueueDepth = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input item channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [u2c_pkg::ByteW-1:0]   byte_value_i,
  input  logic [u2c_pkg::LeftW-1:0]   bytes_left_i,
  // result item channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [u2c_pkg::CodeW-1:0]   code_point_o,
  output logic                        code_valid_o,
  output logic                        end_of_string_o
);

  // classified byte from the front end
  u2c_pkg::entry_t      front_entry;
  // head of the queue as seen by the back end
  u2c_pkg::queue_head_t head;
  logic                 queue_full;
  logic                 pop;

  // front end: pure classification, no state, so an item is taken
  // whenever the queue has room
  u2c_front u_front (
    .byte_value_i (byte_value_i),
    .bytes_left_i (bytes_left_i),
    .entry_o      (front_entry)
  );

  assign in_ready_o = !queue_full;

  // queue lets the input side keep going while the output stalls
  u2c_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .entry_i (front_entry),
    .full_o  (queue_full),
    .pop_i   (pop),
    .head_o  (head)
  );

  // back end: holds the open sequence and the registered result;
  // bytes that produce no result still retire one per cycle while no result is waiting
  u2c_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .code_point_o    (code_point_o),
    .code_valid_o    (code_valid_o),
    .end_of_string_o (end_of_string_o)
  );

endmodule
